>>> sv/bro_enc_pkg.sv
`default_nettype none
package bro_enc_pkg;

    localparam int RATE_W = 64;
    localparam int KB_W   = RATE_W - 10;
    localparam int REM_W  = 18;
    localparam int PROD_W = 26;

    // Rates above this many kbps saturate the second extended octet.
    localparam logic [KB_W-1:0] KB_SAT2 = KB_W'(65200 * 1024);

    // Boundaries of the lower-octet coding ranges, in kbps.
    localparam logic [REM_W-1:0] UNIT_MAX  = REM_W'(63);
    localparam logic [REM_W-1:0] OCT8_MAX  = REM_W'(568);
    localparam logic [REM_W-1:0] OCT64_MIN = REM_W'(576);
    localparam logic [REM_W-1:0] OCT64_MAX = REM_W'(8640);
    localparam logic [REM_W-1:0] EXT_MIN   = REM_W'(8700);
    localparam logic [REM_W-1:0] E100_MAX  = REM_W'(16000);
    localparam logic [REM_W-1:0] E1M_MIN   = REM_W'(17 * 1024);
    localparam logic [REM_W-1:0] E1M_MAX   = REM_W'(128 * 1024);
    localparam logic [REM_W-1:0] E2M_MIN   = REM_W'(130 * 1024);
    localparam logic [REM_W-1:0] E100_OFS  = REM_W'(8600);
    localparam logic [REM_W-1:0] E1M_OFS   = REM_W'(16 * 1024);
    localparam logic [REM_W-1:0] E2M_OFS   = REM_W'(128 * 1024);

    // Division by 100 is a multiply by ceil(2^19 / 100) and a shift by 19.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [7:0] BASE_RESERVED = 8'hff;
    localparam logic [7:0] BASE_EXT      = 8'hfe;
    localparam logic [7:0] BASE_OCT8     = 8'h40;
    localparam logic [7:0] BASE_GAP8     = 8'h7f;
    localparam logic [7:0] BASE_OCT64    = 8'h80;
    localparam logic [7:0] EXT_E1M       = 8'h4a;
    localparam logic [7:0] EXT_E2M       = 8'hba;
    localparam logic [7:0] EXT2_SAT      = 8'hfe;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_BASE = 2'd1;
    localparam logic [1:0] CNT_EXT  = 2'd2;
    localparam logic [1:0] CNT_EXT2 = 2'd3;

    typedef enum logic [3:0] {
        REG_NONE,
        REG_UNIT,
        REG_OCT8,
        REG_GAP8,
        REG_OCT64,
        REG_GAP64,
        REG_E100,
        REG_E100SAT,
        REG_E1M,
        REG_E1MSAT,
        REG_E2M
    } region_t;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             hi;
        logic             sat;
        logic [7:0]       ext2_raw;
        logic [REM_W-1:0] rem;
    } s1_t;

    typedef struct packed {
        logic              valid;
        logic              zero;
        logic              hi;
        region_t           region;
        logic [7:0]        ext2;
        logic [REM_W-1:0]  rem;
        logic [PROD_W-1:0] prod;
    } s2_t;

endpackage
`default_nettype wire

>>> sv/bro_enc_split.sv
`default_nettype none
module bro_enc_split (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [bro_enc_pkg::RATE_W-1:0]  rate_bps,
    output bro_enc_pkg::s1_t                     s1
);

    logic [bro_enc_pkg::KB_W-1:0] kb;
    bro_enc_pkg::s1_t             s1_reg;
    bro_enc_pkg::s1_t             s1_next;

    assign kb = rate_bps[bro_enc_pkg::RATE_W-1:10];

    // The remainder below the 256-Mbps step is always the low bits of kbps,
    // whether or not the second extended octet is in use.
    always_comb
    begin
        s1_next.valid    = start;
        s1_next.zero     = (kb == '0);
        s1_next.hi       = (kb[bro_enc_pkg::KB_W-1:bro_enc_pkg::REM_W] != '0);
        s1_next.sat      = (kb > bro_enc_pkg::KB_SAT2);
        s1_next.ext2_raw = kb[bro_enc_pkg::REM_W+7:bro_enc_pkg::REM_W];
        s1_next.rem      = kb[bro_enc_pkg::REM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule
`default_nettype wire

>>> sv/bro_enc_classify.sv
`default_nettype none
module bro_enc_classify (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bro_enc_pkg::s1_t s1,
    output bro_enc_pkg::s2_t      s2
);

    bro_enc_pkg::s2_t                   s2_reg;
    bro_enc_pkg::s2_t                   s2_next;
    logic [bro_enc_pkg::REM_W-1:0]      x100;
    bro_enc_pkg::region_t               region;

    always_comb
    begin
        if (s1.rem == '0)
            region = bro_enc_pkg::REG_NONE;
        else if (s1.rem <= bro_enc_pkg::UNIT_MAX)
            region = bro_enc_pkg::REG_UNIT;
        else if (s1.rem <= bro_enc_pkg::OCT8_MAX)
            region = bro_enc_pkg::REG_OCT8;
        else if (s1.rem < bro_enc_pkg::OCT64_MIN)
            region = bro_enc_pkg::REG_GAP8;
        else if (s1.rem <= bro_enc_pkg::OCT64_MAX)
            region = bro_enc_pkg::REG_OCT64;
        else if (s1.rem < bro_enc_pkg::EXT_MIN)
            region = bro_enc_pkg::REG_GAP64;
        else if (s1.rem <= bro_enc_pkg::E100_MAX)
            region = bro_enc_pkg::REG_E100;
        else if (s1.rem < bro_enc_pkg::E1M_MIN)
            region = bro_enc_pkg::REG_E100SAT;
        else if (s1.rem <= bro_enc_pkg::E1M_MAX)
            region = bro_enc_pkg::REG_E1M;
        else if (s1.rem < bro_enc_pkg::E2M_MIN)
            region = bro_enc_pkg::REG_E1MSAT;
        else
            region = bro_enc_pkg::REG_E2M;
    end

    // Only meaningful in the 100-kbps range, where the offset fits 13 bits.
    assign x100 = s1.rem - bro_enc_pkg::E100_OFS;

    always_comb
    begin
        s2_next.valid  = s1.valid;
        s2_next.zero   = s1.zero;
        s2_next.hi     = s1.hi;
        s2_next.region = region;
        s2_next.rem    = s1.rem;
        s2_next.prod   = x100[12:0] * bro_enc_pkg::RECIP_100;
        if (s1.sat)
            s2_next.ext2 = bro_enc_pkg::EXT2_SAT;
        else if (s1.hi)
            s2_next.ext2 = s1.ext2_raw;
        else
            s2_next.ext2 = 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule
`default_nettype wire

>>> sv/bro_enc_format.sv
`default_nettype none
module bro_enc_format (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bro_enc_pkg::s2_t s2,
    input  wire logic             zero_mode,
    output logic                  done,
    output logic [7:0]            base_octet,
    output logic [7:0]            ext_octet,
    output logic [7:0]            ext2_octet,
    output logic [1:0]            octet_count
);

    logic                                done_reg;
    logic [7:0]                          base_reg;
    logic [7:0]                          base_next;
    logic [7:0]                          ext_reg;
    logic [7:0]                          ext_next;
    logic [7:0]                          ext2_reg;
    logic [7:0]                          ext2_next;
    logic [1:0]                          count_reg;
    logic [1:0]                          count_next;
    logic [9:0]                          d8;
    logic [13:0]                         d64;
    logic [bro_enc_pkg::REM_W-1:0]       d1m;
    logic [bro_enc_pkg::REM_W-1:0]       d2m;
    logic [6:0]                          q100;

    assign d8   = s2.rem[9:0] - 10'd64;
    assign d64  = s2.rem[13:0] - bro_enc_pkg::OCT64_MIN[13:0];
    assign d1m  = s2.rem - bro_enc_pkg::E1M_OFS;
    assign d2m  = s2.rem - bro_enc_pkg::E2M_OFS;
    assign q100 = s2.prod[bro_enc_pkg::PROD_W-1:bro_enc_pkg::RECIP_SHIFT];

    always_comb
    begin
        ext_next  = 8'd0;
        base_next = bro_enc_pkg::BASE_EXT;
        case (s2.region)
            bro_enc_pkg::REG_NONE:    base_next = 8'd0;
            bro_enc_pkg::REG_UNIT:    base_next = s2.rem[7:0];
            bro_enc_pkg::REG_OCT8:    base_next = bro_enc_pkg::BASE_OCT8 + {2'b00, d8[8:3]};
            bro_enc_pkg::REG_GAP8:    base_next = bro_enc_pkg::BASE_GAP8;
            bro_enc_pkg::REG_OCT64:   base_next = bro_enc_pkg::BASE_OCT64 + {1'b0, d64[12:6]};
            bro_enc_pkg::REG_GAP64:   base_next = bro_enc_pkg::BASE_EXT;
            bro_enc_pkg::REG_E100:    ext_next  = {1'b0, q100};
            bro_enc_pkg::REG_E100SAT: ext_next  = bro_enc_pkg::EXT_E1M;
            bro_enc_pkg::REG_E1M:     ext_next  = bro_enc_pkg::EXT_E1M + {1'b0, d1m[16:10]};
            bro_enc_pkg::REG_E1MSAT:  ext_next  = bro_enc_pkg::EXT_E2M;
            bro_enc_pkg::REG_E2M:     ext_next  = bro_enc_pkg::EXT_E2M + {2'b00, d2m[16:11]};
            default:                  base_next = 8'd0;
        endcase

        if (s2.hi)
            count_next = bro_enc_pkg::CNT_EXT2;
        else if (ext_next != 8'd0)
            count_next = bro_enc_pkg::CNT_EXT;
        else
            count_next = bro_enc_pkg::CNT_BASE;
        ext2_next = s2.ext2;

        // A rate below 1 kbps follows the zero-rate mode.
        if (s2.zero)
        begin
            base_next  = zero_mode ? 8'd0 : bro_enc_pkg::BASE_RESERVED;
            ext_next   = 8'd0;
            ext2_next  = 8'd0;
            count_next = zero_mode ? bro_enc_pkg::CNT_NONE : bro_enc_pkg::CNT_BASE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        ext_reg   <= ext_next;
        ext2_reg  <= ext2_next;
        count_reg <= count_next;
    end

    assign done        = done_reg;
    assign base_octet  = base_reg;
    assign ext_octet   = ext_reg;
    assign ext2_octet  = ext2_reg;
    assign octet_count = count_reg;

endmodule
`default_nettype wire

>>> sv/bit_rate_octet_encoder.sv
// Bit-rate octet encoder.
//
// Input: raise start with rate_bps (bit/s) for one cycle; the transaction
// is taken at that clock edge. busy is always low, so a new rate may be
// given in every cycle.
// Output: done is high for exactly one cycle while base_octet, ext_octet,
// ext2_octet and octet_count hold the encoding. Results pass through the
// split, classify and format registers in the order the rates were given;
// the receiver cannot stall them and must take them when done is high.
// Throughput is one transaction per cycle through a three-stage pipeline:
// split into kbps and remainder, range classification with the multiply
// by the reciprocal of 100, then octet formatting.
// Configuration: cfg_wr_en writes cfg_wr_data into the zero-rate mode
// (0: zero gives 0xff with one octet, 1: all zero with count 0). Write it
// only while no transaction is in flight.
// Reset clears the pipeline valid bits and sets the zero-rate mode to 0.
`default_nettype none
module bit_rate_octet_encoder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [bro_enc_pkg::RATE_W-1:0]  rate_bps,
    input  wire logic                            cfg_wr_en,
    input  wire logic                            cfg_wr_data,
    output logic                                 done,
    output logic [7:0]                           base_octet,
    output logic [7:0]                           ext_octet,
    output logic [7:0]                           ext2_octet,
    output logic [1:0]                           octet_count
);

    logic             zero_mode_reg;
    bro_enc_pkg::s1_t s1;
    bro_enc_pkg::s2_t s2;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            zero_mode_reg <= cfg_wr_data;
        end
    end

    bro_enc_split u_split (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .rate_bps (rate_bps),
        .s1       (s1)
    );

    bro_enc_classify u_classify (
        .clk   (clk),
        .rst_n (rst_n),
        .s1    (s1),
        .s2    (s2)
    );

    bro_enc_format u_format (
        .clk         (clk),
        .rst_n       (rst_n),
        .s2          (s2),
        .zero_mode   (zero_mode_reg),
        .done        (done),
        .base_octet  (base_octet),
        .ext_octet   (ext_octet),
        .ext2_octet  (ext2_octet),
        .octet_count (octet_count)
    );

endmodule
`default_nettype wire

>>> sv/bro_enc_checker.sv
`default_nettype none
module bro_enc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        done,
    input  wire logic [7:0]  base_octet,
    input  wire logic [7:0]  ext_octet,
    input  wire logic [7:0]  ext2_octet,
    input  wire logic [1:0]  octet_count
);

    // Every transaction produces exactly one result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 done)
        else $error("result missing three cycles after start");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result without a matching transaction");

    a_empty_code: assert property (@(posedge clk) disable iff (!rst_n)
        done && octet_count == 2'd0 |->
            base_octet == 8'd0 && ext_octet == 8'd0 && ext2_octet == 8'd0)
        else $error("zero octet count with nonzero octets");

    a_ext2_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && ext2_octet != 8'd0 |-> octet_count == 2'd3)
        else $error("second extended octet used without count 3");

    a_ext_base: assert property (@(posedge clk) disable iff (!rst_n)
        done && ext_octet != 8'd0 |-> base_octet == 8'hfe)
        else $error("extended octet used without full base octet");

endmodule

bind bit_rate_octet_encoder bro_enc_checker u_bro_enc_checker (.*);
`default_nettype wire

>>> test/bro_octet_checker.sv
module bro_octet_checker
    import bro_enc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [RATE_W-1:0] rate_bps,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              done,
    input  logic [7:0]        base_octet,
    input  logic [7:0]        ext_octet,
    input  logic [7:0]        ext2_octet,
    input  logic [1:0]        octet_count,
    output int                mismatches,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] base;
        logic [7:0] ext;
        logic [7:0] ext2;
        logic [1:0] count;
    } octets_t;

    localparam logic [53:0] KB_STEP = 54'd262144;
    localparam logic [53:0] KB_SAT  = 54'd66764800;

    localparam int UNIT_TOP  = 63;
    localparam int OCT8_LOW  = 64;
    localparam int OCT8_TOP  = 568;
    localparam int OCT64_LOW = 576;
    localparam int OCT64_TOP = 8640;
    localparam int EXT_LOW   = 8700;
    localparam int E100_OFS  = 8600;
    localparam int E100_TOP  = 16000;
    localparam int E1M_OFS   = 16 * 1024;
    localparam int E1M_LOW   = 17 * 1024;
    localparam int E1M_TOP   = 128 * 1024;
    localparam int E2M_OFS   = 128 * 1024;
    localparam int E2M_LOW   = 130 * 1024;

    octets_t expected_octets[$];
    octets_t got_oct;
    octets_t want_oct;
    logic    zero_mode;
    int      fail_count;

    function automatic octets_t encode_rate(input logic [63:0] rate, input logic zmode);
        logic [53:0] kb;
        int          rem;
        octets_t     enc;
        kb = rate[63:10];
        enc = '0;
        if (kb == '0)
        begin
            if (!zmode)
            begin
                enc.base = BASE_RESERVED;
                enc.count = CNT_BASE;
            end
            return enc;
        end
        if (kb > KB_SAT)
        begin
            enc.ext2 = EXT2_SAT;
            enc.count = CNT_EXT2;
        end
        else if (kb >= KB_STEP)
        begin
            enc.ext2 = 8'(kb / KB_STEP);
            enc.count = CNT_EXT2;
        end
        // Whole 256 Mbps steps are gone; what is left is the low 18 bits of kbps.
        rem = int'(kb[17:0]);
        if (rem == 0)
            return enc;
        if (rem <= UNIT_TOP)
            enc.base = 8'(rem);
        else if (rem <= OCT8_TOP)
            enc.base = BASE_OCT8 + 8'((rem - OCT8_LOW) / 8);
        else if (rem < OCT64_LOW)
            enc.base = BASE_GAP8;
        else if (rem <= OCT64_TOP)
            enc.base = BASE_OCT64 + 8'((rem - OCT64_LOW) / 64);
        else
            enc.base = BASE_EXT;
        if (rem >= EXT_LOW)
        begin
            if (rem <= E100_TOP)
                enc.ext = 8'((rem - E100_OFS) / 100);
            else if (rem < E1M_LOW)
                enc.ext = EXT_E1M;
            else if (rem <= E1M_TOP)
                enc.ext = EXT_E1M + 8'((rem - E1M_OFS) / 1024);
            else if (rem < E2M_LOW)
                enc.ext = EXT_E2M;
            else
                enc.ext = EXT_E2M + 8'((rem - E2M_OFS) / 2048);
            if (enc.count < CNT_EXT)
                enc.count = CNT_EXT;
        end
        else if (enc.count < CNT_BASE)
        begin
            enc.count = CNT_BASE;
        end
        return enc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_mode = 1'b0;
            fail_count = 0;
            expected_octets.delete();
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                zero_mode = cfg_wr_data;
            if (start && !busy)
                expected_octets.push_back(encode_rate(rate_bps, zero_mode));
            if (done)
            begin
                got_oct = '{base_octet, ext_octet, ext2_octet, octet_count};
                if (expected_octets.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with no transaction pending: %h %h %h %0d",
                                 $realtime, got_oct.base, got_oct.ext, got_oct.ext2,
                                 got_oct.count);
                end
                else
                begin
                    want_oct = expected_octets.pop_front();
                    if (got_oct.base !== want_oct.base || got_oct.ext !== want_oct.ext ||
                        got_oct.ext2 !== want_oct.ext2 || got_oct.count !== want_oct.count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: expected %h %h %h %0d, got %h %h %h %0d",
                                     $realtime, want_oct.base, want_oct.ext, want_oct.ext2,
                                     want_oct.count, got_oct.base, got_oct.ext,
                                     got_oct.ext2, got_oct.count);
                    end
                end
            end
            mismatches <= fail_count;
            outstanding <= expected_octets.size();
        end
    end

endmodule

>>> test/tb_bit_rate_octet_encoder.sv
module tb_bit_rate_octet_encoder;
    import bro_enc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [RATE_W-1:0] rate_bps;
    logic              cfg_wr_en;
    logic              cfg_wr_data;
    logic              done;
    logic [7:0]        base_octet;
    logic [7:0]        ext_octet;
    logic [7:0]        ext2_octet;
    logic [1:0]        octet_count;
    int                mismatches;
    int                outstanding;
    int                cycle_count = 0;
    bit                no_idle;

    // Rates in kbps at the edges of every coding range.
    logic [53:0] boundary_kbps [25] = '{
        54'd0, 54'd1, 54'd63, 54'd64, 54'd568, 54'd571, 54'd575, 54'd576,
        54'd8640, 54'd8641, 54'd8699, 54'd8700, 54'd16000, 54'd16001,
        54'd17407, 54'd17408, 54'd131072, 54'd131073, 54'd133119, 54'd133120,
        54'd262143, 54'd262144, 54'd66764800, 54'd66764801, {54{1'b1}}
    };

    bit_rate_octet_encoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .rate_bps    (rate_bps),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .base_octet  (base_octet),
        .ext_octet   (ext_octet),
        .ext2_octet  (ext2_octet),
        .octet_count (octet_count)
    );

    bro_octet_checker octet_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .rate_bps    (rate_bps),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .base_octet  (base_octet),
        .ext_octet   (ext_octet),
        .ext2_octet  (ext2_octet),
        .octet_count (octet_count),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bit_rate_octet_encoder: mismatch");
            $finish;
        end
    end

    // Start stays high across back-to-back transactions; it is lowered for a gap and while results drain.
    task automatic send_rate(input logic [63:0] rate);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        rate_bps <= rate;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_zero_mode(input logic mode);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly a single range of the lower octets, sometimes stacked on a
    // 256 Mbps multiple, a saturated upper part, or fully random bits.
    function automatic logic [63:0] random_rate();
        logic [35:0] hi;
        logic [17:0] lo;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick == 9)
            return {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0:       lo = '0;
            1:       lo = 18'($urandom_range(1, 63));
            2:       lo = 18'($urandom_range(64, 568));
            3:       lo = 18'($urandom_range(569, 575));
            4:       lo = 18'($urandom_range(576, 8640));
            5:       lo = 18'($urandom_range(8641, 8699));
            6:       lo = 18'($urandom_range(8700, 16000));
            7:       lo = 18'($urandom_range(16001, 17407));
            8:       lo = 18'($urandom_range(17408, 131072));
            9:       lo = 18'($urandom_range(131073, 133119));
            10:      lo = 18'($urandom_range(133120, 262143));
            default: lo = boundary_kbps[$urandom_range(0, 20)][17:0];
        endcase
        if (pick == 6 || pick == 7)
            hi = 36'($urandom_range(1, 254));
        else if (pick == 8)
        begin
            hi = 36'({$urandom, $urandom} >> $urandom_range(28, 63));
            if (hi < 36'd255)
                hi = hi + 36'd255;
        end
        else
            hi = '0;
        return {hi, lo, 10'($urandom)};
    endfunction

    initial
    begin
        int phase;
        rst_n = 1'b0;
        start = 1'b0;
        rate_bps = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        no_idle = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (boundary_kbps[i])
            send_rate({boundary_kbps[i], 10'($urandom)});
        send_rate(64'd1023);

        write_zero_mode(1'b1);
        send_rate(64'd0);
        send_rate(64'd1023);
        send_rate({54'd262144 * 54'd7, 10'd0});
        send_rate({54'd1, 10'd1023});

        for (phase = 0; phase < 3; phase++)
        begin
            write_zero_mode(phase[0] ? 1'b1 : 1'b0);
            repeat (phase == 2 ? 550 : 600)
            begin
                if ($urandom_range(0, 39) == 0)
                    no_idle = !no_idle;
                send_rate(random_rate());
            end
        end

        drain_results();
        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("bit_rate_octet_encoder: match");
        else
            $display("bit_rate_octet_encoder: mismatch");
        $finish;
    end

endmodule
